/* design/daisy_chain_rx_pec10_checker_defines.svh */
// Assertion macros for the daisy-chain read response PEC10 checker.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef DAISY_CHAIN_RX_PEC10_CHECKER_DEFINES_SVH
`define DAISY_CHAIN_RX_PEC10_CHECKER_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define DCRX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define DCRX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dcrx_pkg.sv */
// Package for the daisy-chain read response PEC10 checker.
// Types, constants and CRC helpers shared by all design files; no dependencies.
`default_nettype none

package dcrx_pkg;

    // Frame geometry
    localparam int unsigned DATA_BYTES = 6;
    localparam int unsigned MAX_CHIPS  = 16;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned CHIP_W     = 4;
    localparam int unsigned COUNT_W    = 5;

    // CRC10
    localparam int unsigned CRC_W      = 10;
    localparam logic [CRC_W-1:0] CRC_SEED = 10'd16;
    localparam logic [CRC_W-1:0] CRC_POLY = 10'h08F;
    localparam int unsigned CRC_STEPS_BYTE = 8;
    localparam int unsigned CRC_STEPS_CNT  = 6;

    // Queue between front and back
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_PEC_HI = 2'd1,
        KIND_PEC_LO = 2'd2
    } dcrx_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } dcrx_in_t;

    typedef struct packed {
        logic [CHIP_W-1:0] chip_index;
        logic [CRC_W-1:0]  computed_pec;
        logic [CRC_W-1:0]  received_pec;
        logic [5:0]        command_counter;
        logic              pec_ok;
        logic              any_error;
        logic              last;
    } dcrx_out_t;

    // Classified word held in the queue
    typedef struct packed {
        logic [7:0] rx_byte;
        dcrx_kind_t kind;
        logic       restart;
    } dcrx_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dcrx_qstat_t;

    // Advance the CRC register by up to eight zero-input shift steps
    function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] r_in,
                                                   input int unsigned steps);
        logic [CRC_W-1:0] r;
        r = r_in;
        for (int i = 0; i < 8; i++) begin
            if (i < steps) begin
                if (r[CRC_W-1])
                    r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
                else
                    r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Clamp the chip count register into 1..MAX_CHIPS
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cc);
        logic [COUNT_W-1:0] e;
        if (cc == '0)
            e = COUNT_W'(1);
        else if (cc > COUNT_W'(MAX_CHIPS))
            e = COUNT_W'(MAX_CHIPS);
        else
            e = cc;
        return e;
    endfunction

endpackage

`default_nettype wire

/* design/dcrx_front.sv */
// Front end: accepts received bytes and tags each as data, first or second PEC byte.
// Depends on dcrx_pkg.
`default_nettype none

module dcrx_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire dcrx_pkg::dcrx_in_t  in_data,
    output logic                     in_stall,
    input  wire dcrx_pkg::dcrx_qstat_t q_stat,
    output logic                     push,
    output dcrx_pkg::dcrx_entry_t    entry
);
    import dcrx_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_base;

    // Stall while the queue has no room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // Classify the word by its place in the chip frame
    always_comb
    begin
        pos_base      = in_data.frame_start ? '0 : pos_reg;
        entry.rx_byte = in_data.rx_byte;
        entry.restart = in_data.frame_start;
        if (pos_base < POS_W'(DATA_BYTES))
            entry.kind = KIND_DATA;
        else if (pos_base == POS_W'(DATA_BYTES))
            entry.kind = KIND_PEC_HI;
        else
            entry.kind = KIND_PEC_LO;
    end

    // Advance the byte position, wrap after the second PEC byte
    always_comb
    begin
        pos_next = pos_reg;
        if (push) begin
            if (entry.kind == KIND_PEC_LO)
                pos_next = '0;
            else
                pos_next = pos_base + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

/* design/dcrx_queue.sv */
// Short queue of classified words between front and back end.
// Depends on dcrx_pkg.
`default_nettype none

module dcrx_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire dcrx_pkg::dcrx_entry_t entry_in,
    input  wire logic                  pop,
    output dcrx_pkg::dcrx_entry_t      entry_out,
    output dcrx_pkg::dcrx_qstat_t      q_stat
);
    import dcrx_pkg::*;

    dcrx_entry_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign entry_out    = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= entry_in;
    end

endmodule

`default_nettype wire

/* design/dcrx_back.sv */
// Back end: runs the CRC10, checks the PEC and holds the result word.
// Depends on dcrx_pkg.
`default_nettype none

module dcrx_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dcrx_pkg::dcrx_entry_t entry,
    input  wire dcrx_pkg::dcrx_qstat_t q_stat,
    output logic                       pop,
    input  wire logic [dcrx_pkg::COUNT_W-1:0] chip_count,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output dcrx_pkg::dcrx_out_t        out_data
);
    import dcrx_pkg::*;

    logic [CRC_W-1:0]   crc_reg;
    logic [CRC_W-1:0]   crc_next;
    logic [7:0]         pec_hi_reg;
    logic [7:0]         pec_hi_next;
    logic [CHIP_W-1:0]  chip_reg;
    logic [CHIP_W-1:0]  chip_next;
    logic               err_reg;
    logic               err_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    dcrx_out_t          out_reg;

    logic               slot_free;
    logic               load;
    logic [CRC_W-1:0]   crc_base;
    logic [CRC_W-1:0]   computed;
    logic [CRC_W-1:0]   received;
    logic               ok;
    logic               is_last;
    dcrx_out_t          result;

    // Take a word unless it yields a result with nowhere to go
    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = !q_stat.empty && ((entry.kind != KIND_PEC_LO) || slot_free);
    assign load      = pop && (entry.kind == KIND_PEC_LO);

    // Finish the CRC with the command counter and compare
    always_comb
    begin
        crc_base = entry.restart ? CRC_SEED : crc_reg;
        computed = crc_shift(crc_reg ^ {pec_hi_reg[7:2], 4'b0000}, CRC_STEPS_CNT);
        received = {pec_hi_reg[1:0], entry.rx_byte};
        ok       = (computed == received);
        is_last  = ({1'b0, chip_reg} == (eff_count(chip_count) - COUNT_W'(1)));

        result.chip_index      = chip_reg;
        result.computed_pec    = computed;
        result.received_pec    = received;
        result.command_counter = pec_hi_reg[7:2];
        result.pec_ok          = ok;
        result.any_error       = err_reg | ~ok;
        result.last            = is_last;
    end

    // Update the running check state per word kind
    always_comb
    begin
        crc_next    = crc_reg;
        pec_hi_next = pec_hi_reg;
        chip_next   = chip_reg;
        err_next    = err_reg;
        if (pop) begin
            unique case (entry.kind)
                KIND_DATA:
                begin
                    crc_next = crc_shift(crc_base ^ {entry.rx_byte, 2'b00}, CRC_STEPS_BYTE);
                    if (entry.restart) begin
                        chip_next = '0;
                        err_next  = 1'b0;
                    end
                end
                KIND_PEC_HI:
                begin
                    pec_hi_next = entry.rx_byte;
                end
                KIND_PEC_LO:
                begin
                    crc_next  = CRC_SEED;
                    err_next  = result.any_error;
                    chip_next = is_last ? '0 : chip_reg + CHIP_W'(1);
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    // Hold the result word until taken
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg       <= CRC_SEED;
            pec_hi_reg    <= '0;
            chip_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            pec_hi_reg    <= pec_hi_next;
            chip_reg      <= chip_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* design/daisy_chain_rx_pec10_checker.sv */
// Top level of the daisy-chain read response PEC10 checker.
// Uses dcrx_pkg, dcrx_front, dcrx_queue, dcrx_back and the assertion macro header.
//
//   Channel   Direction  Handshake              Word
//   in        receive    in_valid / in_stall    dcrx_in_t  (rx_byte, frame_start)
//   out       send       out_valid / out_stall  dcrx_out_t (one per chip frame)
//   cfg       receive    cfg_valid / cfg_ready  chip_count, 5 bits
//
// One byte per cycle sustained while in_stall is low; the back end runs eight CRC
// shift steps per byte combinationally; a second PEC byte adds six more and a compare.
// An accepted second PEC byte reaches out_valid via the queue and output register.
// Reset is asynchronous and clears control state at once; there is no clearing pass.
// A four-word queue parts front and back; in_stall rises only when it is full,
// and data words keep draining while a result waits in the output register.
`default_nettype none

`include "daisy_chain_rx_pec10_checker_defines.svh"

module daisy_chain_rx_pec10_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire dcrx_pkg::dcrx_in_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output dcrx_pkg::dcrx_out_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [dcrx_pkg::COUNT_W-1:0] cfg_data
);
    import dcrx_pkg::*;

    logic [COUNT_W-1:0] chip_count_reg;
    logic [COUNT_W-1:0] chip_count_next;
    logic               push;
    logic               pop;
    dcrx_entry_t        front_entry;
    dcrx_entry_t        head_entry;
    dcrx_qstat_t        q_stat;

    // Take configuration words at any time
    assign cfg_ready       = 1'b1;
    assign chip_count_next = (cfg_valid && cfg_ready) ? cfg_data : chip_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chip_count_reg <= COUNT_W'(1);
        else
            chip_count_reg <= chip_count_next;
    end

    dcrx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (front_entry)
    );

    dcrx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (front_entry),
        .pop       (pop),
        .entry_out (head_entry),
        .q_stat    (q_stat)
    );

    dcrx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry      (head_entry),
        .q_stat     (q_stat),
        .pop        (pop),
        .chip_count (chip_count_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // A mismatch always shows in the sticky error flag
    `DCRX_ASSERT_SAME(a_err_sticky, out_valid && !out_data.pec_ok, out_data.any_error, "mismatch without error flag")

    // The last marker sits on the final chip of the configured chain
    `DCRX_ASSERT_SAME(a_last_index, out_valid && out_data.last, {1'b0, out_data.chip_index} == (eff_count(chip_count_reg) - COUNT_W'(1)), "last on wrong chip")

    // An accepted byte is queued by the next edge
    `DCRX_ASSERT_NEXT(a_push_lands, in_valid && !in_stall, !q_stat.empty, "accepted word lost")

endmodule

`default_nettype wire

/* dv/tb_daisy_chain_rx_pec10_checker.sv */
`timescale 1ns / 1ps
// Testbench for the daisy-chain read response PEC10 checker: feeds response bytes,
// predicts each chip's PEC check result and compares it field by field.
// Depends on dcrx_pkg and the daisy_chain_rx_pec10_checker RTL.

module tb_daisy_chain_rx_pec10_checker;
    import dcrx_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned ITEM_TARGET   = 1700;
    localparam int unsigned PHASE_ITEMS   = 250;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    dcrx_in_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    dcrx_out_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data  = '0;

    daisy_chain_rx_pec10_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predicted checker state, starting from the reset values
    logic [CRC_W-1:0]   crc_acc   = CRC_SEED;
    int unsigned        byte_pos  = 0;
    logic [CHIP_W-1:0]  chip_idx  = '0;
    logic [7:0]         pec_hi    = '0;
    logic               err_seen  = 1'b0;
    logic [COUNT_W-1:0] chips_cfg = 5'd1;

    dcrx_in_t  byte_words[$];
    dcrx_out_t chip_results_due[$];

    int unsigned items_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;
    int          in_gap       = 0;
    int          out_hold     = 0;
    bit          in_calm      = 1'b0;
    bit          out_calm     = 1'b0;
    logic        in_taken     = 1'b0;
    logic        out_taken    = 1'b0;
    logic        cfg_taken    = 1'b0;

    // Shift the PEC register with zero input, MSB first
    function automatic logic [CRC_W-1:0] pec_advance(input logic [CRC_W-1:0] r_in,
                                                     input int unsigned steps);
        logic [CRC_W-1:0] r;
        r = r_in;
        for (int i = 0; i < steps; i++)
            r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {r[CRC_W-2:0], 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR result %0d: %s is 0x%0h, want 0x%0h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Advance the predicted state by one accepted byte; queue the chip result it closes
    task automatic track_response_byte(input dcrx_in_t w);
        dcrx_out_t        res;
        logic [CRC_W-1:0] calc;
        logic [COUNT_W-1:0] span;
        if (w.frame_start) begin
            byte_pos = 0;
            chip_idx = '0;
            err_seen = 1'b0;
            crc_acc  = CRC_SEED;
        end
        if (byte_pos < DATA_BYTES) begin
            crc_acc  = pec_advance(crc_acc ^ {w.rx_byte, 2'b00}, 8);
            byte_pos = byte_pos + 1;
        end else if (byte_pos == DATA_BYTES) begin
            pec_hi   = w.rx_byte;
            byte_pos = byte_pos + 1;
        end else begin
            // fold in the command counter, then compare against the received PEC
            calc = pec_advance(crc_acc ^ {pec_hi[7:2], 4'b0000}, 6);
            res.chip_index      = chip_idx;
            res.computed_pec    = calc;
            res.received_pec    = {pec_hi[1:0], w.rx_byte};
            res.command_counter = pec_hi[7:2];
            res.pec_ok          = (calc == {pec_hi[1:0], w.rx_byte});
            err_seen            = err_seen | ~res.pec_ok;
            res.any_error       = err_seen;
            if (chips_cfg == 0)
                span = 5'd1;
            else if (chips_cfg > MAX_CHIPS)
                span = 5'(MAX_CHIPS);
            else
                span = chips_cfg;
            res.last = ({1'b0, chip_idx} == span - 5'd1);
            chip_idx = res.last ? '0 : chip_idx + 4'd1;
            byte_pos = 0;
            crc_acc  = CRC_SEED;
            chip_results_due.push_back(res);
        end
    endtask

    task automatic push_word(input logic [7:0] b, input bit start);
        dcrx_in_t w;
        w.rx_byte     = b;
        w.frame_start = start;
        byte_words.push_back(w);
        items_queued++;
    endtask

    // Queue one chip frame: data bytes, then the counter and PEC in two bytes.
    // A negative fill means random data; a non-negative forced_pec overrides the PEC.
    task automatic queue_chip(input bit start, input int fill, input logic [5:0] cnt,
                              input bit spoil, input int forced_pec);
        logic [7:0]       d;
        logic [CRC_W-1:0] acc;
        acc = CRC_SEED;
        for (int i = 0; i < DATA_BYTES; i++) begin
            d   = (fill < 0) ? 8'($urandom) : 8'(fill);
            acc = pec_advance(acc ^ {d, 2'b00}, 8);
            push_word(d, start && (i == 0));
        end
        acc = pec_advance(acc ^ {cnt, 4'b0000}, 6);
        if (spoil)
            acc = acc ^ 10'(1 << $urandom_range(0, 9));
        if (forced_pec >= 0)
            acc = 10'(forced_pec);
        push_word({cnt, acc[9:8]}, 1'b0);
        push_word(acc[7:0], 1'b0);
    endtask

    // Wait until every queued word is taken and every chip result is back
    task automatic drain_expected();
        while (words_taken != items_queued || chip_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Drive response words from the pending queue with a random gap before each
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (in_gap != 0 || byte_words.size() == 0) begin
                in_valid <= 1'b0;
                if (in_gap != 0)
                    in_gap <= in_gap - 1;
            end else begin
                in_valid <= 1'b1;
                in_data  <= byte_words.pop_front();
                in_gap   <= in_calm ? 0 : $urandom_range(0, 7);
            end
        end
    end

    // Hold off each result word for a random number of cycles
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_taken)
                out_hold = out_calm ? 0 : $urandom_range(0, 7);
            else if (out_valid && out_hold != 0)
                out_hold = out_hold - 1;
            out_stall <= (out_hold != 0);
        end
    end

    // Track accepted words, predict, and check results
    always @(posedge clk) begin : result_monitor
        dcrx_out_t want;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results still due", cycles,
                     chip_results_due.size());
            $display("Some tests failed");
            $finish;
        end else begin
            in_taken  <= rst_n && in_valid && !in_stall;
            out_taken <= rst_n && out_valid && !out_stall;
            cfg_taken <= rst_n && cfg_valid && cfg_ready;
            if (rst_n) begin
                if (cfg_valid && cfg_ready)
                    chips_cfg = cfg_data;
                if (in_valid && !in_stall) begin
                    track_response_byte(in_data);
                    words_taken++;
                end
                if (out_valid && !out_stall) begin
                    results_seen++;
                    if (chip_results_due.size() == 0) begin
                        report_mismatch("result with nothing due, chip_index",
                                        out_data.chip_index, 0);
                    end else begin
                        want = chip_results_due.pop_front();
                        if (out_data.chip_index != want.chip_index)
                            report_mismatch("chip_index", out_data.chip_index,
                                            want.chip_index);
                        if (out_data.computed_pec != want.computed_pec)
                            report_mismatch("computed_pec", out_data.computed_pec,
                                            want.computed_pec);
                        if (out_data.received_pec != want.received_pec)
                            report_mismatch("received_pec", out_data.received_pec,
                                            want.received_pec);
                        if (out_data.command_counter != want.command_counter)
                            report_mismatch("command_counter", out_data.command_counter,
                                            want.command_counter);
                        if (out_data.pec_ok != want.pec_ok)
                            report_mismatch("pec_ok", out_data.pec_ok, want.pec_ok);
                        if (out_data.any_error != want.any_error)
                            report_mismatch("any_error", out_data.any_error, want.any_error);
                        if (out_data.last != want.last)
                            report_mismatch("last", out_data.last, want.last);
                    end
                end
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] chips_set;
        int unsigned        span;
        int unsigned        kind;
        int unsigned        phase_start;
        int unsigned        extra;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: first chip with no frame_start after reset, all-ones data, top counter
        queue_chip(1'b0, 8'hFF, 6'd63, 1'b0, -1);
        // Start a read on zero data with a zero received PEC
        queue_chip(1'b1, 8'h00, 6'd0, 1'b0, 0);
        // Wrap past the final chip with an all-ones PEC; the error flag stays set
        queue_chip(1'b0, -1, 6'd63, 1'b0, 10'h3FF);

        for (int phase = 0; items_queued < ITEM_TARGET; phase++) begin
            drain_expected();
            case (phase)
                0:       chips_set = 5'd0;
                1:       chips_set = 5'd31;
                2:       chips_set = 5'd16;
                3:       chips_set = 5'd1;
                default: chips_set = 5'($urandom_range(1, MAX_CHIPS));
            endcase
            if (chips_set == 0)
                span = 1;
            else if (chips_set > MAX_CHIPS)
                span = MAX_CHIPS;
            else
                span = chips_set;

            // Write the chip count while nothing is in flight
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= chips_set;
            do @(negedge clk); while (!cfg_taken);
            cfg_valid <= 1'b0;

            in_calm  = (phase == 2) || ($urandom_range(0, 3) == 0);
            out_calm = (phase == 2) || ($urandom_range(0, 3) == 0);

            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind <= 6) begin
                    // Well-formed read, now and then running past the final chip
                    extra = span + ((kind == 6) ? $urandom_range(1, 3) : 0);
                    for (int c = 0; c < extra; c++)
                        queue_chip(c == 0, -1, 6'($urandom), $urandom_range(0, 7) == 0, -1);
                end else if (kind == 7) begin
                    // Cut a read short partway through a chip frame
                    extra = $urandom_range(1, DATA_BYTES + 1);
                    for (int i = 0; i < extra; i++)
                        push_word(8'($urandom), i == 0);
                end else if (kind == 8) begin
                    // Noise with stray frame starts
                    extra = $urandom_range(1, 12);
                    for (int i = 0; i < extra; i++)
                        push_word(8'($urandom), $urandom_range(0, 3) == 0);
                end else begin
                    // Continue the current read without a frame start
                    extra = $urandom_range(1, span);
                    for (int c = 0; c < extra; c++)
                        queue_chip(1'b0, -1, 6'($urandom), $urandom_range(0, 7) == 0, -1);
                end
            end
        end

        drain_expected();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* daisy_chain_rx_pec10_checker.f */
+incdir+design
design/dcrx_pkg.sv
design/dcrx_front.sv
design/dcrx_queue.sv
design/dcrx_back.sv
design/daisy_chain_rx_pec10_checker.sv
dv/tb_daisy_chain_rx_pec10_checker.sv
